// File: hdl/q16_16_restoring_divider_top_defines.svh
// Assertion macros for the Q16.16 restoring divider.
`ifndef Q16_16_RESTORING_DIVIDER_TOP_DEFINES_SVH
`define Q16_16_RESTORING_DIVIDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication or plain property, clocked on aclk, off during reset.
`define QDIV_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("qdiv assertion failed");
// Condition that must never hold.
`define QDIV_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("qdiv assertion failed");
`else
`define QDIV_ASSERT(label, prop)
`define QDIV_NEVER(label, cond)
`endif

`endif

// File: hdl/qdiv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Q16.16 restoring divider.
package qdiv_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = WORD_W + FRAC_W;
    localparam int REM_W     = WORD_W;
    localparam int NUM_CELLS = QUO_W;

    localparam logic [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_OVF  = 2'd1,
        STATUS_DIVZ = 2'd2
    } qdiv_status_t;

    // One slot of the cell chain. nq holds the unused dividend bits on top
    // and the quotient bits found so far at the bottom.
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              divz;
        logic [WORD_W-1:0] dmag;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  nq;
    } qdiv_stage_t;

    // Two's complement magnitude; the most negative value maps to 2^31.
    function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + {{(WORD_W-1){1'b0}}, 1'b1}) : v;
    endfunction

endpackage

// File: hdl/qdiv_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: a single shift, trial subtract and restore.
module qdiv_cell
    import qdiv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  qdiv_stage_t stage_in,
    output qdiv_stage_t stage_out
);

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           fits;
    qdiv_stage_t    stage_next;
    qdiv_stage_t    stage_reg;
    logic           valid_reg;

    always_comb begin
        trial = {stage_in.rem, stage_in.nq[QUO_W-1]};
        diff  = trial - {1'b0, stage_in.dmag};
        fits  = ~diff[REM_W];
        stage_next     = stage_in;
        // when the subtract fails, trial is below dmag so its top bit is clear
        stage_next.rem = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
        stage_next.nq  = {stage_in.nq[QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    always_comb begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// File: hdl/qdiv_round.sv
`timescale 1ns / 1ps
// Final rounding, overflow check and sign fix-up after the last cell.
module qdiv_round
    import qdiv_pkg::*;
(
    input  qdiv_stage_t  stage_in,
    output logic [WORD_W-1:0] quotient,
    output qdiv_status_t status
);

    logic               rnd_up;
    logic [QUO_W:0]     q_rnd;
    logic               ovf;
    logic [WORD_W-1:0]  mag;

    always_comb begin
        // round half away from zero: 2*rem >= dmag
        rnd_up = {stage_in.rem, 1'b0} >= {1'b0, stage_in.dmag};
        q_rnd  = {1'b0, stage_in.nq} + {{QUO_W{1'b0}}, rnd_up};
        ovf    = |q_rnd[QUO_W:WORD_W-1];
        mag    = q_rnd[WORD_W-1:0];

        if (stage_in.divz) begin
            quotient = MOST_NEG;
            status   = STATUS_DIVZ;
        end else if (ovf) begin
            quotient = MOST_NEG;
            status   = STATUS_OVF;
        end else begin
            quotient = stage_in.neg ? (~mag + {{(WORD_W-1){1'b0}}, 1'b1}) : mag;
            status   = STATUS_OK;
        end
    end

endmodule

// File: hdl/q16_16_restoring_divider_top.sv
`timescale 1ns / 1ps
// Top level of the signed Q16.16 restoring divider: input prep, cell chain, output register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_dividend[31:0], s_divisor[31:0] (signed Q16.16)
//  m_      | out | m_valid / m_ready  | m_quotient[31:0] (signed Q16.16), m_status[1:0]
//
// One beat per cycle enters the chain of 48 cells (one quotient bit per cell) while the chain
// advances; a result passes through the cell registers and then the output register.
// Reset clears only the valid bits of the cells and the output register.
// A waiting result freezes the whole chain once the last cell is full; until
// then the chain keeps shifting, so trailing empty slots close up and the
// input keeps taking beats.

`include "q16_16_restoring_divider_top_defines.svh"

module q16_16_restoring_divider_top
    import qdiv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_dividend,
    input  logic signed [WORD_W-1:0] s_divisor,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_quotient,
    output logic [1:0]               m_status
);

    qdiv_stage_t       chain [NUM_CELLS+1];
    logic              adv;
    logic              load;
    logic [WORD_W-1:0] rnd_quotient;
    qdiv_status_t      rnd_status;
    logic              m_valid_reg;
    logic [WORD_W-1:0] m_quotient_reg;
    qdiv_status_t      m_status_reg;

    always_comb begin
        chain[0].valid = s_valid;
        chain[0].neg   = s_dividend[WORD_W-1] ^ s_divisor[WORD_W-1];
        chain[0].divz  = (s_divisor == '0);
        chain[0].dmag  = magnitude(s_divisor);
        chain[0].rem   = '0;
        chain[0].nq    = {magnitude(s_dividend), {FRAC_W{1'b0}}};
    end

    assign load    = m_ready || !m_valid_reg;
    assign adv     = load || !chain[NUM_CELLS].valid;
    assign s_ready = adv;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        qdiv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    qdiv_round u_round (
        .stage_in (chain[NUM_CELLS]),
        .quotient (rnd_quotient),
        .status   (rnd_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= chain[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_quotient_reg <= rnd_quotient;
            m_status_reg   <= rnd_status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_quotient = m_quotient_reg;
    assign m_status   = m_status_reg;

    // error cases always carry the most negative quotient
    `QDIV_ASSERT(a_err_value, m_valid && m_status != STATUS_OK |-> m_quotient == MOST_NEG)
    // a good result never equals the most negative value
    `QDIV_NEVER(a_ok_not_min, m_valid && m_status == STATUS_OK && m_quotient == MOST_NEG)
    // input only blocks while a result waits downstream
    `QDIV_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready)

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the Q16.16 restoring divider: directed table, then random beats.
module testbench;
    import qdiv_pkg::*;

    localparam int  N_RANDOM    = 550;
    localparam int  N_QUIET     = 80;      // last beats sent with no idling on either side
    localparam int  DRAIN_WAIT  = 60;      // covers the cell chain and output register
    localparam int  HOLD_CYCLES = 250;     // long receiver stall, well past chain depth
    localparam int  HOLD_AFTER  = 120;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  N_DIRECTED  = 23;

    typedef struct packed {
        logic [WORD_W-1:0] quotient;
        qdiv_status_t      status;
    } quot_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
        logic              typed;      // expected value given in the row itself
        logic [WORD_W-1:0] quotient;
        qdiv_status_t      status;
    } div_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [WORD_W-1:0] s_dividend;
    logic signed [WORD_W-1:0] s_divisor;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [WORD_W-1:0] m_quotient;
    logic [1:0]               m_status;

    quot_beat_t pending_quots[$];
    int         err_cnt   = 0;
    int         sent_cnt  = 0;
    int         cycle_cnt = 0;
    bit         bursts_on = 1'b1;

    // -1.0, -0.5 and 3.0 etc. written as raw Q16.16 words
    div_row_t div_rows [N_DIRECTED] = '{
        '{32'h0001_0000, 32'h0000_0000, 1'b1, MOST_NEG,     STATUS_DIVZ},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, MOST_NEG,     STATUS_DIVZ},
        '{MOST_NEG,      32'h0000_0000, 1'b1, MOST_NEG,     STATUS_DIVZ},
        '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_0000, STATUS_OK},
        '{32'h0000_0000, MOST_NEG,      1'b1, 32'h0000_0000, STATUS_OK},
        '{32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, STATUS_OK},
        '{32'h7FFF_FFFF, 32'h0001_0000, 1'b1, 32'h7FFF_FFFF, STATUS_OK},
        '{MOST_NEG,      32'h0001_0000, 1'b1, MOST_NEG,     STATUS_OVF},
        '{MOST_NEG,      32'hFFFF_0000, 1'b1, MOST_NEG,     STATUS_OVF},
        '{MOST_NEG,      MOST_NEG,      1'b1, 32'h0001_0000, STATUS_OK},
        '{32'h0000_0001, MOST_NEG,      1'b1, 32'h0000_0000, STATUS_OK},
        '{32'h7FFF_FFFF, 32'h0000_0001, 1'b1, MOST_NEG,     STATUS_OVF},
        '{32'h0000_0001, 32'h0002_0000, 1'b1, 32'h0000_0001, STATUS_OK},
        '{32'hFFFF_FFFF, 32'h0002_0000, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
        '{32'h0003_0000, 32'h0002_0000, 1'b1, 32'h0001_8000, STATUS_OK},
        '{32'h4000_0000, 32'hFFFF_8000, 1'b1, MOST_NEG,     STATUS_OVF},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000, STATUS_OK},
        '{32'h0001_0000, 32'h0003_0000, 1'b0, 32'h0,        STATUS_OK},
        '{32'hFFFE_0000, 32'h0003_0000, 1'b0, 32'h0,        STATUS_OK},
        '{32'h1234_5678, 32'hFEDC_BA98, 1'b0, 32'h0,        STATUS_OK},
        '{32'h3FFF_C000, 32'h0000_8000, 1'b0, 32'h0,        STATUS_OK},
        '{32'h0000_0001, 32'h0000_0003, 1'b0, 32'h0,        STATUS_OK},
        '{32'h8000_0001, 32'h7FFF_FFFF, 1'b0, 32'h0,        STATUS_OK}
    };

    q16_16_restoring_divider_top u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_dividend (s_dividend),
        .s_divisor  (s_divisor),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_quotient (m_quotient),
        .m_status   (m_status)
    );

    // Rounded signed quotient num/den, ties away from zero.
    function automatic quot_beat_t divide_q16(input logic [WORD_W-1:0] num,
                                              input logic [WORD_W-1:0] den);
        logic [63:0]       num_mag;
        logic [63:0]       den_mag;
        logic [63:0]       scaled;
        logic [63:0]       quo;
        logic [63:0]       rem;
        logic [WORD_W-1:0] res;
        if (den == '0)
            return '{MOST_NEG, STATUS_DIVZ};
        num_mag = {32'h0, magnitude(num)};
        den_mag = {32'h0, magnitude(den)};
        scaled  = num_mag << FRAC_W;
        quo     = scaled / den_mag;
        rem     = scaled - quo * den_mag;
        if ((rem << 1) >= den_mag)
            quo = quo + 64'd1;
        if (quo >= 64'h8000_0000)
            return '{MOST_NEG, STATUS_OVF};
        res = quo[WORD_W-1:0];
        if (num[WORD_W-1] ^ den[WORD_W-1])
            res = ~res + 32'd1;
        return '{res, STATUS_OK};
    endfunction

    function automatic void pick_operands(output logic [WORD_W-1:0] num,
                                          output logic [WORD_W-1:0] den);
        int          kind;
        logic [31:0] k;
        logic [31:0] q;
        kind = $urandom_range(0, 99);
        num  = $urandom;
        den  = $urandom;
        if (kind < 35) begin
            // full range as drawn
        end else if (kind < 60) begin
            num = $signed(num) >>> $urandom_range(0, 31);
            den = $signed(den) >>> $urandom_range(0, 31);
        end else if (kind < 70) begin
            // tiny divisor, mostly overflow
            den = $urandom_range(1, 32'h0000_FFFF);
            if ($urandom_range(0, 1) == 1)
                den = ~den + 32'd1;
        end else if (kind < 80) begin
            // exact half remainder: rounding tie
            k   = $urandom_range(1, 1000);
            q   = $urandom_range(0, 1000);
            num = k * (2 * q + 1);
            den = (2 * k) << FRAC_W;
            if ($urandom_range(0, 1) == 1)
                num = ~num + 32'd1;
            if ($urandom_range(0, 1) == 1)
                den = ~den + 32'd1;
        end else if (kind < 85) begin
            den = '0;
        end else if (kind < 90) begin
            case ($urandom_range(0, 2))
                0: num = MOST_NEG;
                1: den = MOST_NEG;
                default: begin
                    num = MOST_NEG;
                    den = MOST_NEG;
                end
            endcase
        end else if (kind < 95) begin
            num = '0;
        end else begin
            // quotient close to the 2^31 boundary
            num = $urandom_range(32'h3FFF_0000, 32'h7FFF_FFFF);
            den = 32'h0000_8000 + $urandom_range(0, 8) - 4;
            if ($urandom_range(0, 1) == 1)
                num = ~num + 32'd1;
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[q16_16_restoring_divider_top] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off so the chain backs up.
    initial begin
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && sent_cnt >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (bursts_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        quot_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_quots.size() == 0) begin
                err_cnt = err_cnt + 1;
                $display("%0t: result beat with none expected: quotient %h status %0d",
                         $time, m_quotient, m_status);
            end else begin
                want = pending_quots.pop_front();
                if (m_quotient !== want.quotient) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: quotient expected %h actual %h",
                             $time, want.quotient, m_quotient);
                end
                if (m_status !== want.status) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                end
            end
        end
    end

    initial begin
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
        quot_beat_t        want;
        int                total;
        total = N_DIRECTED + N_RANDOM;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_dividend <= '0;
        s_divisor  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < total; i++) begin
            if (i < N_DIRECTED) begin
                num  = div_rows[i].dividend;
                den  = div_rows[i].divisor;
                want = div_rows[i].typed
                     ? quot_beat_t'{div_rows[i].quotient, div_rows[i].status}
                     : divide_q16(num, den);
            end else begin
                pick_operands(num, den);
                want = divide_q16(num, den);
            end
            if (i >= total - N_QUIET)
                bursts_on = 1'b0;
            if (bursts_on && $urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            s_valid    <= 1'b1;
            s_dividend <= num;
            s_divisor  <= den;
            do
                @(posedge aclk);
            while (!s_ready);
            pending_quots.push_back(want);
            sent_cnt = sent_cnt + 1;
        end
        s_valid <= 1'b0;

        while (pending_quots.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0)
            $display("[q16_16_restoring_divider_top] OK");
        else
            $display("[q16_16_restoring_divider_top] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/qdiv_pkg.sv
hdl/qdiv_cell.sv
hdl/qdiv_round.sv
hdl/q16_16_restoring_divider_top.sv
test/testbench.sv
